/* sv/mbe_pkg.sv */
// Shared types and constants of the Mandelbrot escape-time block.
package mbe_pkg;

  localparam int C_W     = 48;  // c_real / c_imag
  localparam int CNT_W   = 8;   // escape_count / gray_level
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int LIMIT_W = 9;   // iteration_limit
  localparam int LIMB_W  = 16;  // multiplier digit handled by one cell

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr above the byte offset
  localparam logic REG_LIMIT = 1'b0;

  // which product a beat in the multiplier chain carries
  typedef enum logic [1:0] {
    PROD_RR,
    PROD_II,
    PROD_RI
  } prod_e;

  typedef struct packed {
    logic  valid;
    prod_e tag;
  } beat_ctl_t;

endpackage

/* sv/mbe_in_if.sv */
// Point channel: one complex point c per beat.
interface mbe_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [mbe_pkg::C_W-1:0]    c_real;
  logic signed [mbe_pkg::C_W-1:0]    c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

/* sv/mbe_out_if.sv */
// Result channel: escape count, inside flag and gray level per beat.
interface mbe_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbe_pkg::CNT_W-1:0]   escape_count;
  logic                        inside_res;
  logic [mbe_pkg::CNT_W-1:0]   gray_level;

  modport source (output valid, output escape_count, output inside_res,
                  output gray_level, input ready);
  modport sink   (input valid, input escape_count, input inside_res,
                  input gray_level, output ready);
endinterface

/* sv/mandelbrot_escape_time.sv */
// Mandelbrot escape-time unit: takes one point c (signed Q4.44 real and imaginary
// parts) per beat, iterates z = z*z + c from z = 0 up to min(iteration_limit,
// MAX_STEPS) times and returns the zero-based step at which |z|^2 first exceeds 4
// (saturated to 255), or the inside flag with count 0. One point is worked on at a
// time. Each step passes through the states UPDATE, CHECK, ISSUE, WAIT and TEST;
// NC = ceil((FRACTION_BITS + 2) / 16) is the length of the multiplier cell row that
// forms zr*zr, zi*zi and zr*zi one beat after another (NC = 3 at the default
// FRACTION_BITS). The result sits in an output register, so the next point is taken
// while it waits. iteration_limit lives at byte address 0 of the APB port and
// resets to 256.
module mandelbrot_escape_time #(
  parameter int MAX_STEPS     = 256,
  parameter int FRACTION_BITS = 44
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mbe_in_if.sink                        in_i,
  mbe_out_if.source                     out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mbe_pkg::APB_AW-1:0]    paddr,
  input  logic [mbe_pkg::APB_DW-1:0]    pwdata,
  output logic [mbe_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int MW     = FRACTION_BITS + 2;  // |zr|, |zi| <= 2 before each product
  localparam int PW     = 2 * MW;
  localparam int NW     = ((FRACTION_BITS + 3 > mbe_pkg::C_W) ?
                           FRACTION_BITS + 3 : mbe_pkg::C_W) + 1;
  localparam logic [PW:0]   THRESH  = (PW + 1)'(1) << (2 * FRACTION_BITS + 2);
  localparam logic [NW-1:0] Z_BOUND = NW'(1) << (FRACTION_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_ISSUE  = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_TEST   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]                          state_q, state_d;
  logic [STEP_W-1:0]                   step_q, step_d;
  logic [STEP_W-1:0]                   limit_q, lim_eff;
  mbe_pkg::prod_e                      iss_q, iss_d;
  logic [mbe_pkg::LIMIT_W-1:0]         cfg_limit_q;
  logic                                out_valid_q;
  logic                                out_inside_q;
  logic [mbe_pkg::CNT_W-1:0]           out_cnt_q;

  logic signed [mbe_pkg::C_W-1:0]      cr_q, ci_q;
  logic [PW-1:0]                       sq_r_q, sq_i_q;
  logic signed [PW:0]                  cross_q;
  logic signed [NW-1:0]                nr_q, ni_q;
  logic [MW-1:0]                       mr_q, mi_q;
  logic                                xsign_q;
  logic                                res_inside_q, res_inside_d;
  logic [mbe_pkg::CNT_W-1:0]           res_cnt_q, res_cnt_d, cnt_sat;
  logic                                res_load;

  logic                                in_acc, out_free, cfg_wr;
  logic signed [PW:0]                  re, re_sh, im_sh;
  logic signed [NW-1:0]                nr_d, ni_d;
  logic [NW-1:0]                       mag_r, mag_i;
  logic [PW:0]                         mag_sum;
  logic                                esc_range, esc_mag, step_last;

  mbe_pkg::beat_ctl_t                  ch_in_ctl, ch_out_ctl;
  logic [MW-1:0]                       ch_x, ch_y;
  logic [PW-1:0]                       ch_prod;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.escape_count = out_cnt_q;
  assign out_o.gray_level   = out_cnt_q;
  assign out_o.inside_res   = out_inside_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[mbe_pkg::APB_AW-1] == mbe_pkg::REG_LIMIT);
  assign prdata = (paddr[mbe_pkg::APB_AW-1] == mbe_pkg::REG_LIMIT) ?
                  mbe_pkg::APB_DW'(cfg_limit_q) : '0;

  assign lim_eff = (32'(cfg_limit_q) < MAX_STEPS) ? STEP_W'(cfg_limit_q) :
                                                    STEP_W'(MAX_STEPS);

  // z update from the products of the previous z; floor by arithmetic shift
  always_comb begin
    re    = $signed({1'b0, sq_r_q}) - $signed({1'b0, sq_i_q});
    re_sh = re >>> FRACTION_BITS;
    im_sh = cross_q >>> (FRACTION_BITS - 1);  // 2*zr*zi / 2^F
    nr_d  = NW'(re_sh) + NW'(cr_q);
    ni_d  = NW'(im_sh) + NW'(ci_q);
  end

  // a component above 2 escapes by itself; otherwise the squares decide
  assign mag_r     = nr_q[NW-1] ? NW'(-nr_q) : NW'(nr_q);
  assign mag_i     = ni_q[NW-1] ? NW'(-ni_q) : NW'(ni_q);
  assign esc_range = (mag_r > Z_BOUND) || (mag_i > Z_BOUND);
  assign mag_sum   = {1'b0, sq_r_q} + {1'b0, sq_i_q};
  assign esc_mag   = mag_sum > THRESH;
  assign step_last = (step_q + STEP_W'(1)) == limit_q;
  assign cnt_sat   = (32'(step_q) > mbe_pkg::CNT_MAX) ? mbe_pkg::CNT_W'(mbe_pkg::CNT_MAX)
                                                      : mbe_pkg::CNT_W'(step_q);

  // product beats into the cell row
  always_comb begin
    ch_in_ctl.valid = (state_q == S_ISSUE);
    ch_in_ctl.tag   = iss_q;
    unique case (iss_q)
      mbe_pkg::PROD_RR: begin
        ch_x = mr_q;
        ch_y = mr_q;
      end
      mbe_pkg::PROD_II: begin
        ch_x = mi_q;
        ch_y = mi_q;
      end
      default: begin
        ch_x = mr_q;
        ch_y = mi_q;
      end
    endcase
  end

  mbe_chain #(
    .MW (MW)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ch_in_ctl),
    .x_i    (ch_x),
    .y_i    (ch_y),
    .ctl_o  (ch_out_ctl),
    .prod_o (ch_prod)
  );

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    iss_d        = iss_q;
    res_load     = 1'b0;
    res_inside_d = 1'b0;
    res_cnt_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          step_d = '0;
          if (lim_eff == '0) begin
            res_load     = 1'b1;
            res_inside_d = 1'b1;
            state_d      = S_DONE;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end
      S_UPDATE: state_d = S_CHECK;
      S_CHECK: begin
        if (esc_range) begin
          res_load  = 1'b1;
          res_cnt_d = cnt_sat;
          state_d   = S_DONE;
        end else begin
          iss_d   = mbe_pkg::PROD_RR;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        unique case (iss_q)
          mbe_pkg::PROD_RR: iss_d = mbe_pkg::PROD_II;
          mbe_pkg::PROD_II: iss_d = mbe_pkg::PROD_RI;
          default:          state_d = S_WAIT;
        endcase
      end
      S_WAIT: begin
        if (ch_out_ctl.valid && (ch_out_ctl.tag == mbe_pkg::PROD_RI)) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (esc_mag) begin
          res_load  = 1'b1;
          res_cnt_d = cnt_sat;
          state_d   = S_DONE;
        end else if (step_last) begin
          res_load     = 1'b1;
          res_inside_d = 1'b1;
          state_d      = S_DONE;
        end else begin
          step_d  = step_q + STEP_W'(1);
          state_d = S_UPDATE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      limit_q     <= '0;
      iss_q       <= mbe_pkg::PROD_RR;
      out_valid_q <= 1'b0;
      cfg_limit_q <= mbe_pkg::LIMIT_RESET;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iss_q   <= iss_d;
      if (in_acc) begin
        limit_q <= lim_eff;
      end
      if (cfg_wr) begin
        cfg_limit_q <= pwdata[mbe_pkg::LIMIT_W-1:0];
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.valid && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cr_q    <= in_i.c_real;
      ci_q    <= in_i.c_imag;
      sq_r_q  <= '0;
      sq_i_q  <= '0;
      cross_q <= '0;
    end else if (ch_out_ctl.valid) begin
      unique case (ch_out_ctl.tag)
        mbe_pkg::PROD_RR: sq_r_q <= ch_prod;
        mbe_pkg::PROD_II: sq_i_q <= ch_prod;
        default: cross_q <= xsign_q ? -$signed({1'b0, ch_prod}) : $signed({1'b0, ch_prod});
      endcase
    end
    if (state_q == S_UPDATE) begin
      nr_q <= nr_d;
      ni_q <= ni_d;
    end
    if (state_q == S_CHECK) begin
      mr_q    <= MW'(mag_r);
      mi_q    <= MW'(mag_i);
      xsign_q <= nr_q[NW-1] ^ ni_q[NW-1];
    end
    if (res_load) begin
      res_inside_q <= res_inside_d;
      res_cnt_q    <= res_cnt_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_inside_q <= res_inside_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

endmodule

/* sv/mbe_cell.sv */
// One multiplier cell: folds the top digit of y into the running product.
module mbe_cell #(
  parameter int MW = 46,
  parameter int YW = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mbe_pkg::beat_ctl_t   ctl_i,
  input  logic [MW+YW-1:0]     acc_i,
  input  logic [MW-1:0]        x_i,
  input  logic [YW-1:0]        y_i,
  output mbe_pkg::beat_ctl_t   ctl_o,
  output logic [MW+YW-1:0]     acc_o,
  output logic [MW-1:0]        x_o,
  output logic [YW-1:0]        y_o
);

  localparam int AW = MW + YW;
  localparam int LW = mbe_pkg::LIMB_W;

  logic [LW-1:0]    limb;
  logic [MW+LW-1:0] prod;
  logic [AW-1:0]    acc_d;

  assign limb  = y_i[YW-1 -: LW];
  assign prod  = {{LW{1'b0}}, x_i} * {{MW{1'b0}}, limb};
  // MSB-first digit: shift what we have up one digit, add the new row
  assign acc_d = (acc_i << LW) + AW'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_o <= acc_d;
    x_o   <= x_i;
    y_o   <= y_i << LW;
  end

endmodule

/* sv/mbe_chain.sv */
// Row of multiplier cells; one unsigned x*y product enters per cycle.
module mbe_chain #(
  parameter int MW = 46
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mbe_pkg::beat_ctl_t   ctl_i,
  input  logic [MW-1:0]        x_i,
  input  logic [MW-1:0]        y_i,
  output mbe_pkg::beat_ctl_t   ctl_o,
  output logic [2*MW-1:0]      prod_o
);

  localparam int LW = mbe_pkg::LIMB_W;
  localparam int NC = (MW + LW - 1) / LW;
  localparam int YW = NC * LW;
  localparam int AW = MW + YW;

  mbe_pkg::beat_ctl_t ctl [NC+1];
  logic [AW-1:0]      acc [NC+1];
  logic [MW-1:0]      xs  [NC+1];
  logic [YW-1:0]      ys  [NC+1];

  assign ctl[0] = ctl_i;
  assign acc[0] = '0;
  assign xs[0]  = x_i;
  assign ys[0]  = YW'(y_i);

  for (genvar k = 0; k < NC; k++) begin : g_cell
    mbe_cell #(
      .MW (MW),
      .YW (YW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[k]),
      .acc_i  (acc[k]),
      .x_i    (xs[k]),
      .y_i    (ys[k]),
      .ctl_o  (ctl[k+1]),
      .acc_o  (acc[k+1]),
      .x_o    (xs[k+1]),
      .y_o    (ys[k+1])
    );
  end

  assign ctl_o  = ctl[NC];
  assign prod_o = acc[NC][2*MW-1:0];

endmodule

/* sv/mbe_checker.sv */
// Port-level checks of the escape-time unit, bound to the top level.
module mbe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mbe_pkg::CNT_W-1:0]   escape_count_i,
  input logic                        inside_res_i,
  input logic [mbe_pkg::CNT_W-1:0]   gray_level_i
);

  // one point at a time: after a beat is taken, no new one until it is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input ready right after an accepted beat");

  a_inside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && inside_res_i) |-> (escape_count_i == '0) && (gray_level_i == '0))
    else $error("inside point with nonzero count or gray level");

  a_gray_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (gray_level_i == escape_count_i))
    else $error("gray level differs from escape count");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(escape_count_i) && $stable(inside_res_i) && $stable(gray_level_i)))
    else $error("result payload changed while stalled");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .escape_count_i (out_o.escape_count),
  .inside_res_i   (out_o.inside_res),
  .gray_level_i   (out_o.gray_level)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the escape-time unit: directed points, then random phases per limit.
module tb_top;

  localparam int FRAC_BITS = 44;
  localparam int STEP_CAP  = 256;
  localparam longint ONE   = longint'(1) << FRAC_BITS;
  localparam longint C_MAX = (ONE << 3) - 1;
  localparam longint C_MIN = -(ONE << 3);
  localparam logic [127:0] ESC_THRESH = 128'd1 << (2 * FRAC_BITS + 2);
  localparam logic [mbe_pkg::APB_AW-1:0] LIMIT_ADDR = {mbe_pkg::REG_LIMIT, 2'b00};
  localparam int LIMIT_CYCLES = 15_000_000;
  localparam int DRAIN_CYCLES = 2400;
  localparam int NUM_PHASES   = 9;

  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [mbe_pkg::CNT_W-1:0] cnt;
    logic                      ins;
    logic [mbe_pkg::CNT_W-1:0] gray;
  } pixel_t;

  typedef struct packed {
    logic [mbe_pkg::LIMIT_W-1:0] lim;
    logic [mbe_pkg::C_W-1:0]     cr;
    logic [mbe_pkg::C_W-1:0]     ci;
    logic                        fixed_res;
    pixel_t                      px;
  } point_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mbe_pkg::APB_AW-1:0] paddr;
  logic [mbe_pkg::APB_DW-1:0] pwdata;
  logic [mbe_pkg::APB_DW-1:0] prdata;
  logic                       pready;

  mbe_in_if  in_if ();
  mbe_out_if out_if ();

  mandelbrot_escape_time #(
    .MAX_STEPS    (STEP_CAP),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pixel_t                      pixel_q[$];
  point_row_t                  point_rows[$];
  pixel_t                      exp_px;
  logic [mbe_pkg::LIMIT_W-1:0] cur_limit;
  idle_mode_e                  idle_mode;
  int                          errors;
  int                          cycles;
  int phase_lim[NUM_PHASES] = '{1, 8, 32, 100, 256, 511, 0, 3, 255};
  int phase_len[NUM_PHASES] = '{200, 300, 300, 150, 100, 60, 50, 130, 60};

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Iterate z = z*z + c with exact 128-bit products, floor shift back to Q.44.
  function automatic pixel_t escape_point(input logic signed [mbe_pkg::C_W-1:0] cr,
                                          input logic signed [mbe_pkg::C_W-1:0] ci,
                                          input logic [mbe_pkg::LIMIT_W-1:0] lim);
    logic signed [63:0]  zr, zi, nr, ni, cr64, ci64;
    logic signed [127:0] zr_w, zi_w, re_w, im_w, sh_r, sh_i;
    logic [63:0]         mr, mi;
    logic [127:0]        mag;
    int                  steps;
    int                  i;
    bit                  done;
    pixel_t              px;
    steps = (lim < STEP_CAP) ? int'(lim) : STEP_CAP;
    px.cnt = '0;
    px.ins = 1'b1;
    px.gray = '0;
    zr = '0;
    zi = '0;
    cr64 = cr;
    ci64 = ci;
    done = 1'b0;
    for (i = 0; i < steps && !done; i++) begin
      zr_w = zr;
      zi_w = zi;
      re_w = zr_w * zr_w - zi_w * zi_w;
      im_w = (zr_w * zi_w) <<< 1;
      sh_r = re_w >>> FRAC_BITS;
      sh_i = im_w >>> FRAC_BITS;
      nr = sh_r[63:0] + cr64;
      ni = sh_i[63:0] + ci64;
      mr = nr[63] ? (64'd0 - nr) : nr;
      mi = ni[63] ? (64'd0 - ni) : ni;
      mag = {64'd0, mr} * {64'd0, mr} + {64'd0, mi} * {64'd0, mi};
      zr = nr;
      zi = ni;
      if (mag > ESC_THRESH) begin
        done = 1'b1;
        px.ins = 1'b0;
        px.cnt = (i > mbe_pkg::CNT_MAX) ? mbe_pkg::CNT_W'(mbe_pkg::CNT_MAX)
                                        : mbe_pkg::CNT_W'(i);
        px.gray = px.cnt;
      end
    end
    return px;
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SRC:  return $urandom_range(99) < 61;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit sink_stalls();
    case (idle_mode)
      IDLE_SNK:  return $urandom_range(99) < 61;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic add_row(input logic [mbe_pkg::LIMIT_W-1:0] lim, input longint cr,
                         input longint ci, input bit fixed_res, input int cnt,
                         input bit ins);
    point_row_t row;
    row.lim = lim;
    row.cr = mbe_pkg::C_W'(cr);
    row.ci = mbe_pkg::C_W'(ci);
    row.fixed_res = fixed_res;
    row.px.cnt = mbe_pkg::CNT_W'(cnt);
    row.px.ins = ins;
    row.px.gray = ins ? '0 : mbe_pkg::CNT_W'(cnt);
    point_rows.push_back(row);
  endtask

  // Mostly points around the set, some near slow-escaping boundary spots, some raw noise.
  task automatic gen_point(output logic [mbe_pkg::C_W-1:0] cr,
                           output logic [mbe_pkg::C_W-1:0] ci);
    longint unsigned r0, r1;
    longint          br, bi, jr, ji;
    int              pick;
    pick = $urandom_range(99);
    r0 = {$urandom, $urandom};
    r1 = {$urandom, $urandom};
    if (pick < 10) begin
      cr = mbe_pkg::C_W'(r0);
      ci = mbe_pkg::C_W'(r1);
    end else if (pick < 30) begin
      br = 0;
      bi = 0;
      case ($urandom_range(3))
        0: br = ONE / 4;
        1: br = -3 * ONE / 4;
        2: br = -5 * ONE / 4;
        default: bi = ONE;
      endcase
      jr = ((longint'($urandom) << 7) - (longint'(1) << 38)) >>> $urandom_range(8);
      ji = ((longint'($urandom) << 7) - (longint'(1) << 38)) >>> $urandom_range(8);
      cr = mbe_pkg::C_W'(br + jr);
      ci = mbe_pkg::C_W'(bi + ji);
    end else begin
      cr = mbe_pkg::C_W'(longint'(r0 % (3 * ONE)) - 9 * ONE / 4);
      ci = mbe_pkg::C_W'(longint'(r1 % (3 * ONE)) - 3 * ONE / 2);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_point(input logic [mbe_pkg::C_W-1:0] cr,
                            input logic [mbe_pkg::C_W-1:0] ci,
                            input bit fixed_res, input pixel_t fixed_px);
    while (sender_idles()) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.c_real <= cr;
    in_if.c_imag <= ci;
    do @(posedge clk_i); while (!in_if.ready);
    pixel_q.push_back(fixed_res ? fixed_px : escape_point(cr, ci, cur_limit));
    @(negedge clk_i);
  endtask

  task automatic apb_xfer(input bit wr, input logic [mbe_pkg::APB_AW-1:0] addr,
                          input logic [mbe_pkg::APB_DW-1:0] wdata,
                          output logic [mbe_pkg::APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
  endtask

  task automatic check_limit_reg(input logic [mbe_pkg::LIMIT_W-1:0] want);
    logic [mbe_pkg::APB_DW-1:0] rd;
    apb_xfer(1'b0, LIMIT_ADDR, '0, rd);
    if (rd[mbe_pkg::LIMIT_W-1:0] !== want) begin
      errors++;
      $display("%0t: iteration_limit read expected %0d got %0d", $time, want,
               rd[mbe_pkg::LIMIT_W-1:0]);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Between phases or when a directed row changes the limit, once every pending result is out.
  task automatic set_limit(input logic [mbe_pkg::LIMIT_W-1:0] v);
    logic [mbe_pkg::APB_DW-1:0] rd;
    while (pixel_q.size() != 0) @(posedge clk_i);
    apb_xfer(1'b1, LIMIT_ADDR, mbe_pkg::APB_DW'(v), rd);
    cur_limit = v;
    check_limit_reg(v);
  endtask

  task automatic check_field(input string name, input logic [mbe_pkg::CNT_W-1:0] want,
                             input logic [mbe_pkg::CNT_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= !sink_stalls();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: count %0d inside %0d gray %0d", $time,
                 out_if.escape_count, out_if.inside_res, out_if.gray_level);
      end else begin
        exp_px = pixel_q.pop_front();
        check_field("escape_count", exp_px.cnt, out_if.escape_count);
        check_field("inside_res", mbe_pkg::CNT_W'(exp_px.ins),
                    mbe_pkg::CNT_W'(out_if.inside_res));
        check_field("gray_level", exp_px.gray, out_if.gray_level);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [mbe_pkg::C_W-1:0] cr, ci;
    point_row_t              row;
    int                      p;
    int                      k;
    errors = 0;
    cycles = 0;
    cur_limit = mbe_pkg::LIMIT_RESET;
    idle_mode = IDLE_NONE;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.c_real = '0;
    in_if.c_imag = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    check_limit_reg(mbe_pkg::LIMIT_RESET);

    // lim, c_real, c_imag, fixed result?, count, inside
    add_row(256, 0, 0, 1, 0, 1);
    add_row(256, C_MAX, C_MAX, 1, 0, 0);
    add_row(256, C_MIN, C_MIN, 1, 0, 0);
    add_row(256, C_MAX, C_MIN, 1, 0, 0);
    add_row(256, C_MIN, C_MAX, 1, 0, 0);
    add_row(256, -2 * ONE, 0, 1, 0, 1);   // |z|^2 sits exactly at 4, never above
    add_row(256, -ONE, 0, 1, 0, 1);
    add_row(256, 2 * ONE, 0, 0, 0, 0);
    add_row(256, 0, 2 * ONE, 0, 0, 0);
    add_row(256, ONE / 4, 0, 0, 0, 0);
    add_row(256, ONE / 4 + ONE / 64, 0, 0, 0, 0);
    add_row(256, -3 * ONE / 4, ONE / 10, 0, 0, 0);
    add_row(256, -3 * ONE / 4, 0, 0, 0, 0);
    add_row(256, 0, ONE, 0, 0, 0);
    add_row(256, 64'h5555_5555_5555, 64'hAAAA_AAAA_AAAA, 0, 0, 0);
    add_row(256, 64'hAAAA_AAAA_AAAA, 64'h5555_5555_5555, 0, 0, 0);
    add_row(1, 0, 0, 1, 0, 1);
    add_row(1, ONE, 0, 1, 0, 1);
    add_row(1, 3 * ONE, 0, 1, 0, 0);
    add_row(0, C_MAX, C_MAX, 1, 0, 1);    // no step tried
    add_row(0, 0, 0, 1, 0, 1);
    add_row(511, 0, 0, 1, 0, 1);          // limit above the step cap (MAX_STEPS = 256)
    add_row(511, -3 * ONE / 4, ONE / 10, 0, 0, 0);
    add_row(2, 2 * ONE, 0, 1, 1, 0);

    idle_mode = IDLE_BOTH;
    foreach (point_rows[i]) begin
      row = point_rows[i];
      if (row.lim != cur_limit) begin
        in_if.valid <= 1'b0;
        set_limit(row.lim);
      end
      send_point(row.cr, row.ci, row.fixed_res, row.px);
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      in_if.valid <= 1'b0;
      set_limit(mbe_pkg::LIMIT_W'(phase_lim[p]));
      idle_mode = idle_mode_e'(p % 4);
      for (k = 0; k < phase_len[p]; k++) begin
        gen_point(cr, ci);
        send_point(cr, ci, 1'b0, '0);
      end
    end
    in_if.valid <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
sv/mbe_pkg.sv
sv/mbe_in_if.sv
sv/mbe_out_if.sv
sv/mbe_cell.sv
sv/mbe_chain.sv
sv/mandelbrot_escape_time.sv
sv/mbe_checker.sv
test/tb_top.sv
